// ===== rtl/lsps_pkg.sv =====
// Package for the line sensor PD steering block: types, register indexes,
// microcode words and the sensor pattern table. No dependencies.
`default_nettype none
package lsps_pkg;

    localparam int unsigned PatW   = 8;
    localparam int unsigned DutyW  = 10;
    localparam int unsigned AngleW = 5;
    localparam int unsigned HoldW  = 9;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDatW = 10;
    localparam int unsigned StepW  = 3;
    localparam int unsigned OpndW  = 14;
    localparam int unsigned AccW   = 18;
    localparam int unsigned SumW   = 19;

    localparam logic [DutyW-1:0]  DutyMax  = 10'd1023;
    localparam logic signed [AngleW-1:0] BarAngle = 5'sd10;

    localparam logic [PatW-1:0] PatBarA = 8'h81;
    localparam logic [PatW-1:0] PatBarB = 8'hC3;
    localparam logic [PatW-1:0] PatBarC = 8'h00;

    localparam logic [CfgIdxW-1:0] REG_BASE_SPEED   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_PROP_GAIN    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_STEER_GAIN   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_BAR_HOLD_LEN = 3'd4;

    localparam logic [StepW-1:0] STEP_IDLE  = 3'd0;
    localparam logic [StepW-1:0] STEP_PROP  = 3'd1;
    localparam logic [StepW-1:0] STEP_DERIV = 3'd2;
    localparam logic [StepW-1:0] STEP_STEER = 3'd3;
    localparam logic [StepW-1:0] STEP_EMIT  = 3'd4;

    localparam logic [1:0] GSEL_PROP  = 2'd0;
    localparam logic [1:0] GSEL_DERIV = 2'd1;
    localparam logic [1:0] GSEL_STEER = 2'd2;

    localparam logic [1:0] OSEL_NEG_ANGLE = 2'd0;
    localparam logic [1:0] OSEL_DIFF      = 2'd1;
    localparam logic [1:0] OSEL_ACC       = 2'd2;

    typedef struct packed {
        logic [DutyW-1:0] base_speed;
        logic [5:0]       prop_gain;
        logic [5:0]       deriv_gain;
        logic [3:0]       steer_gain;
        logic [HoldW-1:0] bar_hold_len;
    } t_cfg;

    typedef struct packed {
        logic             accept;
        logic             emit;
        logic             mul_en;
        logic             acc_add;
        logic [1:0]       gsel;
        logic [1:0]       osel;
        logic [StepW-1:0] ok_step;
        logic [StepW-1:0] wait_step;
    } t_uword;

    typedef struct packed {
        logic       in_fire;
        logic       out_fire;
        logic       mul_en;
        logic       acc_add;
        logic [1:0] gsel;
        logic [1:0] osel;
    } t_ctrl;

    function automatic t_uword ucode(input logic [StepW-1:0] step);
        t_uword w;
        w = '0;
        case (step)
            STEP_IDLE: begin
                w.accept    = 1'b1;
                w.ok_step   = STEP_PROP;
                w.wait_step = STEP_IDLE;
            end
            STEP_PROP: begin
                w.mul_en  = 1'b1;
                w.gsel    = GSEL_PROP;
                w.osel    = OSEL_NEG_ANGLE;
                w.ok_step = STEP_DERIV;
            end
            STEP_DERIV: begin
                w.mul_en  = 1'b1;
                w.acc_add = 1'b1;
                w.gsel    = GSEL_DERIV;
                w.osel    = OSEL_DIFF;
                w.ok_step = STEP_STEER;
            end
            STEP_STEER: begin
                w.mul_en  = 1'b1;
                w.gsel    = GSEL_STEER;
                w.osel    = OSEL_ACC;
                w.ok_step = STEP_EMIT;
            end
            STEP_EMIT: begin
                w.accept    = 1'b1;
                w.emit      = 1'b1;
                w.ok_step   = STEP_PROP;
                w.wait_step = STEP_IDLE;
            end
            default: begin
                w.ok_step   = STEP_IDLE;
                w.wait_step = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    // {known, angle}
    function automatic logic [AngleW:0] pattern_angle(input logic [PatW-1:0] p);
        logic [AngleW:0] r;
        case (p)
            8'hFE:   r = {1'b1, 5'sd12};
            8'hFC:   r = {1'b1, 5'sd10};
            8'hFD:   r = {1'b1, 5'sd9};
            8'hF9:   r = {1'b1, 5'sd7};
            8'hFB:   r = {1'b1, 5'sd5};
            8'hF3:   r = {1'b1, 5'sd3};
            8'hF7:   r = {1'b1, 5'sd2};
            8'hE7:   r = {1'b1, 5'sd0};
            8'hEF:   r = {1'b1, -5'sd2};
            8'hCF:   r = {1'b1, -5'sd3};
            8'hDF:   r = {1'b1, -5'sd5};
            8'h9F:   r = {1'b1, -5'sd7};
            8'hBF:   r = {1'b1, -5'sd9};
            8'h3F:   r = {1'b1, -5'sd10};
            8'h7F:   r = {1'b1, -5'sd12};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/lsps_ifs.sv =====
// Valid/ready channel interfaces for the sensor, result and config ports.
// Depends on lsps_pkg for field widths.
`default_nettype none
interface lsps_in_if;
    logic                      valid;
    logic                      ready;
    logic [lsps_pkg::PatW-1:0] sensor_pattern;
    modport source (output valid, output sensor_pattern, input ready);
    modport sink (input valid, input sensor_pattern, output ready);
endinterface

interface lsps_out_if;
    logic                                valid;
    logic                                ready;
    logic [lsps_pkg::DutyW-1:0]          left_duty;
    logic [lsps_pkg::DutyW-1:0]          right_duty;
    logic signed [lsps_pkg::AngleW-1:0]  angle_used;
    logic                                bar_hold;
    modport source (output valid, output left_duty, output right_duty,
                    output angle_used, output bar_hold, input ready);
    modport sink (input valid, input left_duty, input right_duty,
                  input angle_used, input bar_hold, output ready);
endinterface

interface lsps_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [lsps_pkg::CfgIdxW-1:0] index;
    logic [lsps_pkg::CfgDatW-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/lsps_sequencer.sv =====
// Step counter and microcode lookup; issues the datapath control word.
// Depends on lsps_pkg for the microcode table and control struct.
`default_nettype none
module lsps_sequencer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_out_free,
    output lsps_pkg::t_ctrl      o_ctrl,
    output logic                 o_in_ready
);

    logic [lsps_pkg::StepW-1:0] r_step;
    logic [lsps_pkg::StepW-1:0] n_step;
    lsps_pkg::t_uword           w_word;
    logic                       w_out_stall;
    logic                       w_in_fire;

    assign w_word      = lsps_pkg::ucode(r_step);
    assign w_out_stall = w_word.emit && !i_out_free;
    assign o_in_ready  = w_word.accept && !w_out_stall;
    assign w_in_fire   = o_in_ready && i_in_valid;

    always_comb begin
        o_ctrl.in_fire  = w_in_fire;
        o_ctrl.out_fire = w_word.emit && i_out_free;
        o_ctrl.mul_en   = w_word.mul_en;
        o_ctrl.acc_add  = w_word.acc_add;
        o_ctrl.gsel     = w_word.gsel;
        o_ctrl.osel     = w_word.osel;
    end

    always_comb begin
        if (w_out_stall) begin
            n_step = r_step;
        end else if (w_word.accept && !w_in_fire) begin
            n_step = w_word.wait_step;
        end else begin
            n_step = w_word.ok_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= lsps_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/lsps_datapath.sv =====
// Angle decode, bar hold counter, shared multiplier with accumulator,
// duty saturation and result register. Depends on lsps_pkg.
`default_nettype none
module lsps_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire lsps_pkg::t_ctrl                   i_ctrl,
    input  wire lsps_pkg::t_cfg                    i_cfg,
    input  wire logic [lsps_pkg::PatW-1:0]         i_pattern,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_free,
    output logic                                   o_out_valid,
    output logic [lsps_pkg::DutyW-1:0]             o_left_duty,
    output logic [lsps_pkg::DutyW-1:0]             o_right_duty,
    output logic signed [lsps_pkg::AngleW-1:0]     o_angle_used,
    output logic                                   o_bar_hold
);

    logic signed [lsps_pkg::AngleW-1:0] r_prev;
    logic signed [lsps_pkg::AngleW:0]   r_diff;
    logic                               r_bar;
    logic [lsps_pkg::HoldW-1:0]         r_hold_count;
    logic signed [lsps_pkg::AccW-1:0]   r_acc;

    logic signed [lsps_pkg::AngleW-1:0] n_angle;
    logic                               n_bar;
    logic [lsps_pkg::HoldW-1:0]         n_hold_count;
    logic [lsps_pkg::AngleW:0]          w_lookup;

    logic [5:0]                         w_gain;
    logic signed [lsps_pkg::OpndW-1:0]  w_opnd;
    logic signed [lsps_pkg::OpndW+6:0]  w_prod;
    logic signed [lsps_pkg::AccW-1:0]   w_prod_t;
    logic signed [lsps_pkg::SumW-1:0]   w_base;
    logic signed [lsps_pkg::SumW-1:0]   w_acc_x;
    logic signed [lsps_pkg::SumW-1:0]   w_left_sum;
    logic signed [lsps_pkg::SumW-1:0]   w_right_sum;

    function automatic logic [lsps_pkg::DutyW-1:0] clamp_duty(
        input logic signed [lsps_pkg::SumW-1:0] v
    );
        logic [lsps_pkg::DutyW-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({{(lsps_pkg::SumW-lsps_pkg::DutyW){1'b0}},
                                  lsps_pkg::DutyMax})) begin
            r = lsps_pkg::DutyMax;
        end else begin
            r = v[lsps_pkg::DutyW-1:0];
        end
        return r;
    endfunction

    assign w_lookup = lsps_pkg::pattern_angle(i_pattern);

    always_comb begin
        n_hold_count = r_hold_count;
        n_angle      = lsps_pkg::BarAngle;
        n_bar        = 1'b1;
        if (r_hold_count != '0) begin
            if (r_hold_count < i_cfg.bar_hold_len) begin
                n_hold_count = r_hold_count + lsps_pkg::HoldW'(1);
            end else begin
                n_hold_count = '0;
            end
        end else if (i_pattern inside {lsps_pkg::PatBarA, lsps_pkg::PatBarB,
                                       lsps_pkg::PatBarC}) begin
            n_hold_count = {{(lsps_pkg::HoldW-1){1'b0}}, 1'b1};
        end else begin
            n_bar   = 1'b0;
            n_angle = w_lookup[lsps_pkg::AngleW] ?
                      $signed(w_lookup[lsps_pkg::AngleW-1:0]) : '0;
        end
    end

    always_comb begin
        case (i_ctrl.gsel)
            lsps_pkg::GSEL_PROP:  w_gain = i_cfg.prop_gain;
            lsps_pkg::GSEL_DERIV: w_gain = i_cfg.deriv_gain;
            lsps_pkg::GSEL_STEER: w_gain = {2'b00, i_cfg.steer_gain};
            default:              w_gain = '0;
        endcase
        case (i_ctrl.osel)
            lsps_pkg::OSEL_NEG_ANGLE: w_opnd = -lsps_pkg::OpndW'(r_prev);
            lsps_pkg::OSEL_DIFF:      w_opnd = lsps_pkg::OpndW'(r_diff);
            lsps_pkg::OSEL_ACC:       w_opnd = r_acc[lsps_pkg::OpndW-1:0];
            default:                  w_opnd = '0;
        endcase
    end

    assign w_prod   = w_opnd * $signed({1'b0, w_gain});
    assign w_prod_t = w_prod[lsps_pkg::AccW-1:0];

    assign w_base      = $signed({{(lsps_pkg::SumW-lsps_pkg::DutyW){1'b0}}, i_cfg.base_speed});
    assign w_acc_x     = lsps_pkg::SumW'(r_acc);
    assign w_left_sum  = w_base - w_acc_x;
    assign w_right_sum = w_base + w_acc_x;

    assign o_out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= '0;
            r_hold_count <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_ctrl.in_fire) begin
                r_prev       <= n_angle;
                r_hold_count <= n_hold_count;
            end
            if (i_ctrl.out_fire) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.in_fire) begin
            r_diff <= (lsps_pkg::AngleW+1)'(r_prev) - (lsps_pkg::AngleW+1)'(n_angle);
            r_bar  <= n_bar;
        end
        if (i_ctrl.mul_en) begin
            r_acc <= i_ctrl.acc_add ? r_acc + w_prod_t : w_prod_t;
        end
        if (i_ctrl.out_fire) begin
            o_left_duty  <= clamp_duty(w_left_sum);
            o_right_duty <= clamp_duty(w_right_sum);
            o_angle_used <= r_prev;
            o_bar_hold   <= r_bar;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/line_sensor_pd_steering_top.sv =====
// Top level of the line sensor PD steering block: config registers and
// channel wiring. Depends on lsps_pkg, lsps_ifs, lsps_sequencer, lsps_datapath.
`default_nettype none
// Each sensor beat yields one result beat with both motor duties, the angle
// used and the bar hold flag. A sensor beat is taken in the cycle the previous
// result is written to the output register, so a new beat waits while an item
// is in the proportional, derivative and steer steps, and an item taken by an
// idle block has its result in the output register once those three products
// (proportional, derivative, steer scale) have run in turn through the one
// shared multiplier. A result held by a stalled sink stops the next beat from
// being taken. Config writes are always ready; write them only while no item
// is in flight.
module line_sensor_pd_steering_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lsps_in_if.sink     i_sensor,
    lsps_out_if.source  o_result,
    lsps_cfg_if.sink    i_cfg
);

    lsps_pkg::t_cfg  r_cfg;
    lsps_pkg::t_ctrl w_ctrl;
    logic            w_in_ready;
    logic            w_out_free;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_speed   <= 10'd280;
            r_cfg.prop_gain    <= 6'd7;
            r_cfg.deriv_gain   <= 6'd12;
            r_cfg.steer_gain   <= 4'd2;
            r_cfg.bar_hold_len <= 9'd310;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                lsps_pkg::REG_BASE_SPEED:   r_cfg.base_speed   <= i_cfg.data;
                lsps_pkg::REG_PROP_GAIN:    r_cfg.prop_gain    <= i_cfg.data[5:0];
                lsps_pkg::REG_DERIV_GAIN:   r_cfg.deriv_gain   <= i_cfg.data[5:0];
                lsps_pkg::REG_STEER_GAIN:   r_cfg.steer_gain   <= i_cfg.data[3:0];
                lsps_pkg::REG_BAR_HOLD_LEN: r_cfg.bar_hold_len <= i_cfg.data[8:0];
                default: begin
                end
            endcase
        end
    end

    lsps_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sensor.valid),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl),
        .o_in_ready (w_in_ready)
    );

    assign i_sensor.ready = w_in_ready;

    lsps_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_cfg        (r_cfg),
        .i_pattern    (i_sensor.sensor_pattern),
        .i_out_ready  (o_result.ready),
        .o_out_free   (w_out_free),
        .o_out_valid  (o_result.valid),
        .o_left_duty  (o_result.left_duty),
        .o_right_duty (o_result.right_duty),
        .o_angle_used (o_result.angle_used),
        .o_bar_hold   (o_result.bar_hold)
    );

endmodule
`default_nettype wire

// ===== tb/line_sensor_pd_steering_top_tb.sv =====
// Self-checking bench for line_sensor_pd_steering_top: directed and random sensor beats,
// PD duty prediction, bar hold and saturation checks across several register settings.
// Depends on lsps_pkg, lsps_ifs and the RTL of the block.
`default_nettype none
module line_sensor_pd_steering_top_tb;

    localparam int RUN_LIMIT    = 400000;
    localparam int STALL_CYCLES = 300;
    localparam int SETTLE_CYC   = 8;

    localparam logic [lsps_pkg::PatW-1:0] TRACK_PATS [15] = '{
        8'hFE, 8'hFC, 8'hFD, 8'hF9, 8'hFB, 8'hF3, 8'hF7, 8'hE7,
        8'hEF, 8'hCF, 8'hDF, 8'h9F, 8'hBF, 8'h3F, 8'h7F
    };

    typedef struct packed {
        logic [lsps_pkg::DutyW-1:0]         left_duty;
        logic [lsps_pkg::DutyW-1:0]         right_duty;
        logic signed [lsps_pkg::AngleW-1:0] angle_used;
        logic                               bar_hold;
    } t_steer_res;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lsps_in_if  sens_if ();
    lsps_out_if res_if ();
    lsps_cfg_if cfg_if ();

    line_sensor_pd_steering_top uut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_sensor (sens_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    logic [lsps_pkg::PatW-1:0] pattern_q [$];
    t_steer_res                duty_exp_q [$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_off      = 1'b0;
    int   mismatches    = 0;
    int   cycle_cnt     = 0;

    logic [lsps_pkg::DutyW-1:0] base_speed   = 10'd280;
    logic [5:0]                 prop_gain    = 6'd7;
    logic [5:0]                 deriv_gain   = 6'd12;
    logic [3:0]                 steer_gain   = 4'd2;
    logic [lsps_pkg::HoldW-1:0] bar_hold_len = 9'd310;

    logic signed [lsps_pkg::AngleW-1:0] prev_ang = '0;
    logic [lsps_pkg::HoldW-1:0]         hold_cnt = '0;

    always #1 clk = ~clk;

    function automatic logic [lsps_pkg::DutyW-1:0] clamp_duty(input int v);
        if (v < 0) return '0;
        if (v > int'(lsps_pkg::DutyMax)) return lsps_pkg::DutyMax;
        return v[lsps_pkg::DutyW-1:0];
    endfunction

    function automatic t_steer_res steer_predict(input logic [lsps_pkg::PatW-1:0] pat);
        t_steer_res r;
        int ang;
        int u;
        int d;
        logic hold_f;
        hold_f = 1'b0;
        if (hold_cnt != '0) begin
            if (hold_cnt < bar_hold_len) hold_cnt = hold_cnt + 9'd1;
            else hold_cnt = '0;
            ang = int'(lsps_pkg::BarAngle);
            hold_f = 1'b1;
        end else if (pat inside {lsps_pkg::PatBarA, lsps_pkg::PatBarB, lsps_pkg::PatBarC}) begin
            hold_cnt = 9'd1;
            ang = int'(lsps_pkg::BarAngle);
            hold_f = 1'b1;
        end else begin
            case (pat)
                8'hFE: ang = 12;
                8'hFC: ang = 10;
                8'hFD: ang = 9;
                8'hF9: ang = 7;
                8'hFB: ang = 5;
                8'hF3: ang = 3;
                8'hF7: ang = 2;
                8'hE7: ang = 0;
                8'hEF: ang = -2;
                8'hCF: ang = -3;
                8'hDF: ang = -5;
                8'h9F: ang = -7;
                8'hBF: ang = -9;
                8'h3F: ang = -10;
                8'h7F: ang = -12;
                default: ang = 0;
            endcase
        end
        u = int'(prop_gain) * (0 - ang) + int'(deriv_gain) * (int'(prev_ang) - ang);
        d = int'(steer_gain) * u;
        r.left_duty  = clamp_duty(int'(base_speed) - d);
        r.right_duty = clamp_duty(int'(base_speed) + d);
        r.angle_used = ang[lsps_pkg::AngleW-1:0];
        r.bar_hold   = hold_f;
        prev_ang     = ang[lsps_pkg::AngleW-1:0];
        return r;
    endfunction

    function automatic logic [lsps_pkg::PatW-1:0] pick_pattern();
        int r;
        r = $urandom_range(99);
        if (r < 6) begin
            case ($urandom_range(2))
                0: return lsps_pkg::PatBarA;
                1: return lsps_pkg::PatBarB;
                default: return lsps_pkg::PatBarC;
            endcase
        end
        if (r < 75) return TRACK_PATS[$urandom_range(14)];
        return lsps_pkg::PatW'($urandom_range(255));
    endfunction

    // drive sensor beats
    always @(posedge clk) begin
        if (!rst_n) begin
            sens_if.valid <= 1'b0;
        end else if (!sens_if.valid || sens_if.ready) begin
            if (pattern_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                sens_if.valid          <= 1'b1;
                sens_if.sensor_pattern <= pattern_q.pop_front();
            end else begin
                sens_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || hold_off) res_if.ready <= 1'b0;
        else res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // predict on accepted sensor beats, check result beats
    always @(posedge clk) begin
        t_steer_res want;
        if (!rst_n) begin
            prev_ang = '0;
            hold_cnt = '0;
        end else begin
            if (sens_if.valid && sens_if.ready)
                duty_exp_q.push_back(steer_predict(sens_if.sensor_pattern));
            if (res_if.valid && res_if.ready) begin
                if (duty_exp_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: left=%0d right=%0d angle=%0d hold=%0b",
                                 res_if.left_duty, res_if.right_duty, res_if.angle_used,
                                 res_if.bar_hold);
                end else begin
                    want = duty_exp_q.pop_front();
                    if (want.left_duty !== res_if.left_duty
                        || want.right_duty !== res_if.right_duty
                        || want.angle_used !== res_if.angle_used
                        || want.bar_hold !== res_if.bar_hold) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp left=%0d right=%0d angle=%0d hold=%0b, %s",
                                     want.left_duty, want.right_duty, want.angle_used,
                                     want.bar_hold,
                                     $sformatf("got left=%0d right=%0d angle=%0d hold=%0b",
                                               res_if.left_duty, res_if.right_duty,
                                               res_if.angle_used, res_if.bar_hold));
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [lsps_pkg::CfgIdxW-1:0] idx,
                             input logic [lsps_pkg::CfgDatW-1:0] val);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            lsps_pkg::REG_BASE_SPEED:   base_speed   = val[lsps_pkg::DutyW-1:0];
            lsps_pkg::REG_PROP_GAIN:    prop_gain    = val[5:0];
            lsps_pkg::REG_DERIV_GAIN:   deriv_gain   = val[5:0];
            lsps_pkg::REG_STEER_GAIN:   steer_gain   = val[3:0];
            lsps_pkg::REG_BAR_HOLD_LEN: bar_hold_len = val[lsps_pkg::HoldW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input int base, input int kp, input int kd, input int ks,
                            input int hold_len);
        write_reg(lsps_pkg::REG_BASE_SPEED, lsps_pkg::CfgDatW'(base));
        write_reg(lsps_pkg::REG_PROP_GAIN, lsps_pkg::CfgDatW'(kp));
        write_reg(lsps_pkg::REG_DERIV_GAIN, lsps_pkg::CfgDatW'(kd));
        write_reg(lsps_pkg::REG_STEER_GAIN, lsps_pkg::CfgDatW'(ks));
        write_reg(lsps_pkg::REG_BAR_HOLD_LEN, lsps_pkg::CfgDatW'(hold_len));
    endtask

    task automatic set_random_regs(input int hold_lo, input int hold_hi);
        set_regs($urandom_range(1023), $urandom_range(63), $urandom_range(63),
                 $urandom_range(15), $urandom_range(hold_hi, hold_lo));
    endtask

    task automatic queue_random(input int n);
        repeat (n) pattern_q.push_back(pick_pattern());
    endtask

    // wait until every beat is out, then let the pipeline go quiet
    task automatic settle();
        while (pattern_q.size() != 0 || sens_if.valid || duty_exp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    initial begin
        sens_if.valid          = 1'b0;
        sens_if.sensor_pattern = '0;
        res_if.ready           = 1'b0;
        cfg_if.valid           = 1'b0;
        cfg_if.index           = '0;
        cfg_if.data            = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (TRACK_PATS[i]) pattern_q.push_back(TRACK_PATS[i]);
        pattern_q.push_back(8'hFF);
        pattern_q.push_back(8'h01);
        pattern_q.push_back(8'hAA);
        pattern_q.push_back(8'h55);
        pattern_q.push_back(lsps_pkg::PatBarA);
        queue_random(40);
        settle();

        set_regs(1023, 63, 63, 15, 1);
        pattern_q.push_back(8'h7F);
        pattern_q.push_back(8'hFE);
        pattern_q.push_back(8'h7F);
        pattern_q.push_back(8'hFE);
        pattern_q.push_back(lsps_pkg::PatBarB);
        pattern_q.push_back(8'hFE);
        pattern_q.push_back(lsps_pkg::PatBarC);
        pattern_q.push_back(8'h3F);
        pattern_q.push_back(8'hE7);
        settle();

        set_regs(0, 0, 0, 0, 0);
        pattern_q.push_back(lsps_pkg::PatBarA);
        pattern_q.push_back(8'hFE);
        pattern_q.push_back(8'hFE);
        pattern_q.push_back(8'h7F);
        settle();

        set_random_regs(1, 6);
        send_idle_pct <= 35;
        recv_idle_pct <= 76;
        queue_random(120);
        settle();

        set_random_regs(2, 10);
        send_idle_pct <= 76;
        recv_idle_pct <= 35;
        queue_random(120);
        settle();

        set_random_regs(1, 4);
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        queue_random(120);
        fork
            begin
                @(posedge clk);
                hold_off <= 1'b1;
                repeat (STALL_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        settle();

        set_regs(512, 1, 1, 1, 64);
        pattern_q.push_back(lsps_pkg::PatBarC);
        queue_random(70);
        settle();

        if (mismatches == 0 && duty_exp_q.size() == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
